/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent holds -> consequent holds in the same cycle
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* rtl/mbps_pkg.sv */
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types, constants and the pattern alignment function of the scanner.
// ----------------------------------------------------------------------------
package mbps_pkg;

   localparam int unsigned PATTERN_BYTES_DEF = 16;
   localparam int unsigned OFFSET_BITS_DEF   = 32;

   // configured pattern storage is fixed at 16 bytes
   localparam int unsigned MASK_BITS   = 16;
   localparam int unsigned PAT_HALF_W  = 64;
   localparam int unsigned PLEN_W      = 5;
   localparam int unsigned HOLE_IDX_W  = 4;
   localparam int unsigned RSP_OFF_W   = 32;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 64;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_LOW    = 3'd0,
      CSR_PATTERN_HIGH   = 3'd1,
      CSR_CARE_MASK      = 3'd2,
      CSR_HOLE_MASK      = 3'd3,
      CSR_PATTERN_LENGTH = 3'd4
   } csr_index_type;

   // per-cell view of the pattern: compare enable and expected byte
   typedef struct packed {
      logic       care;
      logic [7:0] pat;
   } cell_cfg_type;

   // Window slot 'slot' (oldest at 0, newest at slots-1) lines up with
   // pattern byte slot + len - slots. Bytes past the configured 16 never care.
   function automatic cell_cfg_type align_cell(
      input logic [PAT_HALF_W-1:0] pat_lo,
      input logic [PAT_HALF_W-1:0] pat_hi,
      input logic [MASK_BITS-1:0]  care,
      input int unsigned           len,
      input int unsigned           slot,
      input int unsigned           slots
   );
      cell_cfg_type c;
      int unsigned  k;
      logic [2:0]   sub;
      c.care = 1'b0;
      c.pat  = '0;
      k      = 0;
      sub    = '0;
      if (slot + len >= slots) begin
         k   = slot + len - slots;
         sub = 3'(k);
         if (k < MASK_BITS) begin
            c.care = care[HOLE_IDX_W'(k)];
            if (k < 8) begin
               c.pat = pat_lo[{sub, 3'b000} +: 8];
            end else begin
               c.pat = pat_hi[{sub, 3'b000} +: 8];
            end
         end
      end
      return c;
   endfunction

endpackage

/* rtl/mbps_if.sv */
// ----------------------------------------------------------------------------
// mbps_if
// Valid/ready channels of the scanner: byte input, result output, CSR writes.
// ----------------------------------------------------------------------------
interface req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            found;
   logic [mbps_pkg::RSP_OFF_W-1:0]  hole_offset;

   modport source (output valid, output found, output hole_offset, input ready);
   modport sink   (input valid, input found, input hole_offset, output ready);
endinterface

interface csr_if;
   logic                             valid;
   logic                             ready;
   logic [mbps_pkg::CSR_INDEX_W-1:0] index;
   logic [mbps_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/mbps_cell.sv */
// ----------------------------------------------------------------------------
// mbps_cell
// One window slot: holds a stream byte, passes it on, compares its next byte.
// ----------------------------------------------------------------------------
module mbps_cell (
   input  logic                   clock,
   input  logic                   shift_en,
   input  logic [7:0]             byte_in,
   input  mbps_pkg::cell_cfg_type cfg,
   output logic [7:0]             byte_out,
   output logic                   hit
);
   import mbps_pkg::*;

   logic [7:0] byte_ff;

   // window contents never need clearing: a window is only judged once
   // every slot in use holds a byte of the current stream
   always_ff @(posedge clock) begin
      if (shift_en) begin
         byte_ff <= byte_in;
      end
   end

   // judged on the byte this slot takes at the current beat
   assign hit      = !cfg.care || (byte_in == cfg.pat);
   assign byte_out = byte_ff;

endmodule

/* rtl/masked_byte_pattern_search.sv */
// ----------------------------------------------------------------------------
// masked_byte_pattern_search
// Scans a byte stream for a masked pattern; reports the first hole offset.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the input is not stalled; the window compare
//   runs in the beat that shifts the byte into the cell chain.
// A result is registered and shown in the cycle after the byte that causes it.
// The input stalls only while the result register is full and not taken.
// Reset (synchronous): config returns to zero with length 1, stream state
//   and the result valid flag clear; window bytes and result data are not reset.
// ----------------------------------------------------------------------------
module masked_byte_pattern_search #(
   parameter int unsigned PATTERN_BYTES = mbps_pkg::PATTERN_BYTES_DEF,
   parameter int unsigned OFFSET_BITS   = mbps_pkg::OFFSET_BITS_DEF
) (
   input  logic  clock,
   input  logic  reset,
   req_if.sink   req,
   rsp_if.source rsp,
   csr_if.sink   csr
);
   import mbps_pkg::*;

   `include "assert_macros.svh"

   localparam int unsigned LEN_W = $clog2(PATTERN_BYTES + 1);

   // configuration
   logic [PAT_HALF_W-1:0] pattern_low_ff;
   logic [PAT_HALF_W-1:0] pattern_high_ff;
   logic [MASK_BITS-1:0]  care_mask_ff;
   logic [MASK_BITS-1:0]  hole_mask_ff;
   logic [PLEN_W-1:0]     pattern_length_ff;

   // stream state
   logic [OFFSET_BITS-1:0] count_ff, count_in;
   logic                   done_ff, done_in;

   // result register
   logic                 rsp_valid_ff;
   logic                 found_ff, found_in;
   logic [RSP_OFF_W-1:0] offset_ff, offset_in;
   logic                 rsp_load;

   logic                     req_fire;
   logic                     scan_en;
   logic [LEN_W-1:0]         len_eff;
   logic [HOLE_IDX_W-1:0]    hole_idx;
   logic                     hole_any;
   logic                     eligible;
   logic                     match;
   logic [OFFSET_BITS-1:0]   offset_full;
   logic [7:0]               cell_byte [PATTERN_BYTES];
   logic [PATTERN_BYTES-1:0] cell_hit;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         care_mask_ff      <= '0;
         hole_mask_ff      <= '0;
         pattern_length_ff <= PLEN_W'(1);
      end else if (csr.valid) begin
         case (csr.index)
            CSR_PATTERN_LOW:    pattern_low_ff    <= csr.data;
            CSR_PATTERN_HIGH:   pattern_high_ff   <= csr.data;
            CSR_CARE_MASK:      care_mask_ff      <= csr.data[MASK_BITS-1:0];
            CSR_HOLE_MASK:      hole_mask_ff      <= csr.data[MASK_BITS-1:0];
            CSR_PATTERN_LENGTH: pattern_length_ff <= csr.data[PLEN_W-1:0];
            default: ;
         endcase
      end
   end

   // length 0 acts as 1, anything above the window acts as the window
   always_comb begin
      if (pattern_length_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (int'(pattern_length_ff) > PATTERN_BYTES) begin
         len_eff = LEN_W'(PATTERN_BYTES);
      end else begin
         len_eff = LEN_W'(pattern_length_ff);
      end
   end

   // lowest hole inside the used part of the pattern
   always_comb begin
      hole_idx = '0;
      hole_any = 1'b0;
      for (int k = MASK_BITS - 1; k >= 0; k--) begin
         if (hole_mask_ff[k] && (k < int'(len_eff))) begin
            hole_idx = HOLE_IDX_W'(k);
            hole_any = 1'b1;
         end
      end
   end

   assign req_fire = req.valid && req.ready;
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign scan_en  = req_fire && !done_ff;

   // cell chain: newest byte enters the top slot, older bytes move down
   for (genvar j = 0; j < PATTERN_BYTES; j++) begin : g_cell
      logic [7:0]   nbr_byte;
      cell_cfg_type slot_cfg;

      if (j == PATTERN_BYTES - 1) begin : g_head
         assign nbr_byte = req.data_byte;
      end else begin : g_body
         assign nbr_byte = cell_byte[j+1];
      end

      assign slot_cfg = align_cell(pattern_low_ff, pattern_high_ff, care_mask_ff,
                                   int'(len_eff), j, PATTERN_BYTES);

      mbps_cell u_cell (
         .clock    (clock),
         .shift_en (scan_en),
         .byte_in  (nbr_byte),
         .cfg      (slot_cfg),
         .byte_out (cell_byte[j]),
         .hit      (cell_hit[j])
      );
   end

   assign eligible    = count_ff >= OFFSET_BITS'(len_eff - LEN_W'(1));
   assign match       = eligible && (&cell_hit) && hole_any;
   // start of window is count - (len - 1)
   assign offset_full = count_ff - OFFSET_BITS'(len_eff) + OFFSET_BITS'(1)
                        + OFFSET_BITS'(hole_idx);

   always_comb begin
      count_in  = count_ff;
      done_in   = done_ff;
      rsp_load  = 1'b0;
      found_in  = 1'b0;
      offset_in = '0;
      if (req_fire) begin
         if (done_ff) begin
            if (req.last_byte) begin
               count_in = '0;
               done_in  = 1'b0;
            end
         end else begin
            if (count_ff != '1) begin
               count_in = count_ff + OFFSET_BITS'(1);
            end
            if (match) begin
               rsp_load  = 1'b1;
               found_in  = 1'b1;
               offset_in = RSP_OFF_W'(offset_full);
               done_in   = !req.last_byte;
            end else if (req.last_byte) begin
               rsp_load = 1'b1;
            end
            if (req.last_byte) begin
               count_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         found_ff  <= found_in;
         offset_ff <= offset_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.found       = found_ff;
   assign rsp.hole_offset = offset_ff;

   `ASSERT_SAME(a_notfound_zero, clock, reset, rsp.valid && !rsp.found, rsp.hole_offset == '0, "not-found beat with nonzero offset")
   `ASSERT_NEXT(a_done_holds, clock, reset, done_ff && req_fire && !req.last_byte, done_ff && !rsp_load, "search ended early after a match")
   `ASSERT_NEXT(a_last_clears, clock, reset, req_fire && req.last_byte, count_ff == '0 && !done_ff, "stream state kept past last beat")
   `ASSERT_SAME(a_load_has_room, clock, reset, rsp_load, !rsp_valid_ff || rsp.ready, "result overwrote a pending beat")

endmodule
